// ----- sv/tfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tfp_pkg;

    localparam int unsigned CHANNEL_W         = 8;
    localparam int unsigned WORD_W            = 64;
    localparam int unsigned TEXEL_W           = 32;
    localparam int unsigned FILL_W            = 7;
    localparam int unsigned TEXEL_N_W         = 6;
    localparam int unsigned CFG_INDEX_W       = 2;
    localparam int unsigned CFG_DATA_W        = 3;
    localparam int unsigned OUT_DEPTH_DEFAULT = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEXEL_SIZE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam logic [1:0] FMT_RGBA = 2'd0;
    localparam logic [1:0] FMT_I    = 2'd1;
    localparam logic [1:0] FMT_IA   = 2'd2;

    localparam logic [1:0] SIZE_4  = 2'd0;
    localparam logic [1:0] SIZE_8  = 2'd1;
    localparam logic [1:0] SIZE_16 = 2'd2;
    localparam logic [1:0] SIZE_32 = 2'd3;

    localparam logic [2:0] CH_GRAY       = 3'd1;
    localparam logic [2:0] CH_GRAY_ALPHA = 3'd2;
    localparam logic [2:0] CH_RGB        = 3'd3;
    localparam logic [2:0] CH_RGBA       = 3'd4;

    localparam logic [1:0] RESET_PIXEL_FORMAT  = FMT_RGBA;
    localparam logic [1:0] RESET_TEXEL_SIZE    = SIZE_32;
    localparam logic [2:0] RESET_CHANNEL_COUNT = CH_RGBA;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic              last_word;
    } out_entry_t;

endpackage

`default_nettype wire

// ----- sv/tfp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tfp_pixel_if
    import tfp_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] first_channel;
    logic [CHANNEL_W-1:0] second_channel;
    logic [CHANNEL_W-1:0] third_channel;
    logic [CHANNEL_W-1:0] fourth_channel;
    logic                 last_pixel;

    modport source (
        output valid, first_channel, second_channel, third_channel, fourth_channel,
               last_pixel,
        input  ready
    );
    modport sink (
        input  valid, first_channel, second_channel, third_channel, fourth_channel,
               last_pixel,
        output ready
    );
endinterface

interface tfp_word_if
    import tfp_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] packed_word;
    logic              last_word;

    modport source (
        output valid, packed_word, last_word,
        input  ready
    );
    modport sink (
        input  valid, packed_word, last_word,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/texel_format_packer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Texel format packer.
// pixels: one source pixel per transfer (four 8-bit channels, last_pixel).
// words: 64-bit texel words, first texel in the top bits; last_word marks
//   the word that closes an image (partial words are zero-filled below).
// cfg_write/cfg_index/cfg_data: format, size and channel count registers;
//   write them only while no pixel is in flight.
// A pixel passes the input register, then is packed into the output queue.
// Throughput: one pixel per cycle while pixels.ready is high; a pixel may
//   produce up to two words, which drain through the output queue at one
//   word per cycle while words.ready is high.
// pixels.ready drops when the output queue could not take two words each
//   for the pixel in the input register and the next one, so a stalled
//   receiver backs up into the pixel stream without losing words.
// Reset clears the registers to rgba / 32 bits / 4 channels, empties the
//   word accumulator and the output queue.
// OUT_DEPTH must be at least 4.
module texel_format_packer
    import tfp_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    tfp_pixel_if.sink                   pixels,
    tfp_word_if.source                  words,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

    logic [1:0] format_reg;
    logic [1:0] size_reg;
    logic [2:0] chans_reg;

    logic                 s1_valid_reg;
    logic [CHANNEL_W-1:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic                 last_reg;

    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    out_entry_t       queue_reg [OUT_DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic accept, pop;

    logic [2:0]            ch_eff;
    logic [CHANNEL_W-1:0]  r, g, b, a, gray;
    logic [15:0]           gray_sum;
    logic [TEXEL_W-1:0]    texel_v, texel_top;
    logic [TEXEL_N_W-1:0]  texel_n;
    logic [WORD_W+TEXEL_W-1:0] window;
    logic [FILL_W-1:0]     fill_sum, fill_mid;
    logic [WORD_W-1:0]     acc_mid;
    logic                  overflow, flush;
    logic [1:0]            push_cnt;
    out_entry_t            entry_a, entry_b;
    logic [PTR_W-1:0]      wr_ptr_1, wr_ptr_2, rd_ptr_1;
    logic [CNT_W+1:0]      need;

    assign accept = pixels.valid && pixels.ready;
    assign pop    = words.valid && words.ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= RESET_PIXEL_FORMAT;
            size_reg   <= RESET_TEXEL_SIZE;
            chans_reg  <= RESET_CHANNEL_COUNT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PIXEL_FORMAT:  format_reg <= cfg_data[1:0];
                REG_TEXEL_SIZE:    size_reg   <= cfg_data[1:0];
                REG_CHANNEL_COUNT: chans_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c0_reg   <= pixels.first_channel;
            c1_reg   <= pixels.second_channel;
            c2_reg   <= pixels.third_channel;
            c3_reg   <= pixels.fourth_channel;
            last_reg <= pixels.last_pixel;
        end
    end

    // texel conversion
    always_comb
    begin
        if (chans_reg == 3'd0)
            ch_eff = CH_GRAY;
        else if (chans_reg > CH_RGBA)
            ch_eff = CH_RGBA;
        else
            ch_eff = chans_reg;

        gray_sum = 16'(c0_reg) * 16'd85 + 16'(c1_reg) * 16'd86 + 16'(c2_reg) * 16'd85;

        if (ch_eff >= CH_RGB)
        begin
            r    = c0_reg;
            g    = c1_reg;
            b    = c2_reg;
            a    = (ch_eff == CH_RGBA) ? c3_reg : 8'hFF;
            gray = gray_sum[15:8];
        end
        else
        begin
            r    = c0_reg;
            g    = c0_reg;
            b    = c0_reg;
            a    = (ch_eff == CH_GRAY_ALPHA) ? c1_reg : 8'hFF;
            gray = c0_reg;
        end

        texel_v = '0;
        texel_n = '0;
        case (format_reg)
            FMT_RGBA:
            begin
                case (size_reg)
                    SIZE_32:
                    begin
                        texel_v = {r, g, b, a};
                        texel_n = 6'd32;
                    end
                    SIZE_16:
                    begin
                        texel_v = {16'd0, r[7:3], g[7:3], b[7:3], a[7]};
                        texel_n = 6'd16;
                    end
                    default: ;
                endcase
            end
            FMT_I:
            begin
                case (size_reg)
                    SIZE_8:
                    begin
                        texel_v = {24'd0, gray};
                        texel_n = 6'd8;
                    end
                    SIZE_4:
                    begin
                        texel_v = {28'd0, gray[7:4]};
                        texel_n = 6'd4;
                    end
                    default: ;
                endcase
            end
            FMT_IA:
            begin
                case (size_reg)
                    SIZE_16:
                    begin
                        texel_v = {16'd0, gray, a};
                        texel_n = 6'd16;
                    end
                    SIZE_8:
                    begin
                        texel_v = {24'd0, gray[7:4], a[7:4]};
                        texel_n = 6'd8;
                    end
                    SIZE_4:
                    begin
                        texel_v = {28'd0, gray[7:5], a[7]};
                        texel_n = 6'd4;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // bit packing
    always_comb
    begin
        texel_top = texel_v << (TEXEL_N_W'(TEXEL_W) - texel_n);
        window    = {acc_reg, TEXEL_W'(0)} | ({texel_top, WORD_W'(0)} >> fill_reg);
        fill_sum  = fill_reg + FILL_W'(texel_n);
        overflow  = fill_sum > FILL_W'(WORD_W);

        if (overflow)
        begin
            acc_mid  = {window[TEXEL_W-1:0], TEXEL_W'(0)};
            fill_mid = fill_sum - FILL_W'(WORD_W);
        end
        else
        begin
            acc_mid  = window[WORD_W+TEXEL_W-1:TEXEL_W];
            fill_mid = fill_sum;
        end

        flush = last_reg && (fill_mid != '0);

        entry_a = '{packed_word: window[WORD_W+TEXEL_W-1:TEXEL_W], last_word: 1'b0};
        entry_b = '{packed_word: acc_mid, last_word: 1'b1};
        if (!overflow)
            entry_a = entry_b;

        push_cnt = '0;
        if (s1_valid_reg)
            push_cnt = 2'(overflow) + 2'(flush);

        acc_next  = acc_reg;
        fill_next = fill_reg;
        if (s1_valid_reg)
        begin
            acc_next  = flush ? '0 : acc_mid;
            fill_next = flush ? '0 : fill_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
        end
    end

    // output queue
    assign wr_ptr_1 = (wr_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign wr_ptr_2 = (wr_ptr_1 == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_1 + 1'b1;
    assign rd_ptr_1 = (rd_ptr_reg == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    assign count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    assign need = (CNT_W+2)'(count_reg) + (CNT_W+2)'({s1_valid_reg, 1'b0}) + (CNT_W+2)'(2);

    assign pixels.ready = need <= (CNT_W+2)'(OUT_DEPTH);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            queue_reg[wr_ptr_reg] <= entry_a;
        if (push_cnt == 2'd2)
            queue_reg[wr_ptr_1] <= entry_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_1;
            case (push_cnt)
                2'd1:    wr_ptr_reg <= wr_ptr_1;
                2'd2:    wr_ptr_reg <= wr_ptr_2;
                default: ;
            endcase
        end
    end

    assign words.valid       = count_reg != '0;
    assign words.packed_word = queue_reg[rd_ptr_reg].packed_word;
    assign words.last_word   = queue_reg[rd_ptr_reg].last_word;

endmodule

`default_nettype wire

// ----- sv/tfp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tfp_checker
    import tfp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [WORD_W-1:0] out_word,
    input wire logic              out_last
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("word valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_word) && $stable(out_last))
        else $error("word payload changed while stalled");

    // a word can only appear after a pixel transfer has passed the input register
    a_word_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_xfer, 2))
        else $error("word appeared without a preceding pixel transfer");

    // empty queue and empty input register always take a pixel
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_xfer) |-> in_ready)
        else $error("pixel input stalled while block is empty");

endmodule

bind texel_format_packer tfp_checker u_tfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (words.valid),
    .out_ready (words.ready),
    .out_word  (words.packed_word),
    .out_last  (words.last_word)
);

`default_nettype wire
